/* rtl/core/vkdh_pkg.sv */
// Shared types and constants for the vertex key dedup hash unit.
`default_nettype none
package vkdh_pkg;

    localparam int FIELD_W            = 24;
    localparam int STATUS_W           = 2;
    localparam int DEFAULT_TABLE_SIZE = 4096;
    localparam int DEFAULT_INDEX_BITS = 24;

    localparam logic [31:0] HASH_MUL_P = 32'd73856093;
    localparam logic [31:0] HASH_MUL_T = 32'd19349663;
    localparam logic [31:0] HASH_MUL_N = 32'd83492791;

    typedef logic [FIELD_W-1:0]  field_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t STATUS_FOUND    = 2'd0;
    localparam status_t STATUS_INSERTED = 2'd1;
    localparam status_t STATUS_FULL     = 2'd2;

endpackage
`default_nettype wire

/* rtl/core/vkdh_if.sv */
// Request and response channel interfaces for the vertex key dedup hash unit.
`default_nettype none
interface vkdh_req_if;
    logic           valid;
    logic           ready;
    vkdh_pkg::field_t position_index;
    vkdh_pkg::field_t texcoord_index;
    vkdh_pkg::field_t normal_index;
    vkdh_pkg::field_t candidate_index;

    modport source (
        output valid, position_index, texcoord_index, normal_index, candidate_index,
        input  ready
    );
    modport sink (
        input  valid, position_index, texcoord_index, normal_index, candidate_index,
        output ready
    );
endinterface

interface vkdh_rsp_if;
    logic              valid;
    logic              ready;
    vkdh_pkg::status_t lookup_status;
    vkdh_pkg::field_t  found_index;

    modport source (
        output valid, lookup_status, found_index,
        input  ready
    );
    modport sink (
        input  valid, lookup_status, found_index,
        output ready
    );
endinterface
`default_nettype wire

/* rtl/core/vertex_key_dedup_hash_unit.sv */
// Top level: vertex key dedup table with linear probing over a single-port memory.
// Flow: S_HASH multiplies the position, texcoord and normal keys in turn and XORs the products;
//   S_MOD reduces that modulo TABLE_SIZE if it is not a power of two; a probe is a registered
//   read in S_PROBE and a compare in S_CMP; S_RESP then loads the output register.
// One transaction at a time (shared multiplier, one memory port); a held response stalls S_RESP.
// Reset: asynchronous, active low; a clearing pass over every slot follows, req.ready low.
`default_nettype none
module vertex_key_dedup_hash_unit #(
    parameter int TABLE_SIZE = vkdh_pkg::DEFAULT_TABLE_SIZE,
    parameter int INDEX_BITS = vkdh_pkg::DEFAULT_INDEX_BITS
) (
    input  wire logic clk,
    input  wire logic rst_n,
    vkdh_req_if.sink  req,
    vkdh_rsp_if.source rsp
);

    localparam int ADDR_W = $clog2(TABLE_SIZE);
    localparam int KEY_W  = (INDEX_BITS < vkdh_pkg::FIELD_W) ? INDEX_BITS : vkdh_pkg::FIELD_W;
    localparam int TKEY_W = 3 * KEY_W;
    localparam bit IS_POW2 = ((TABLE_SIZE & (TABLE_SIZE - 1)) == 0);
    localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(TABLE_SIZE - 1);
    localparam logic [31:0] TABLE_SIZE_32 = 32'(TABLE_SIZE);
    localparam logic [31:0] MOD_RECIP     = 32'((64'd1 << 32) / TABLE_SIZE);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_HASH  = 3'd2;
    localparam logic [2:0] S_MOD   = 3'd3;
    localparam logic [2:0] S_PROBE = 3'd4;
    localparam logic [2:0] S_CMP   = 3'd5;
    localparam logic [2:0] S_RESP  = 3'd6;

    localparam logic [4:0] HASH_LAST = 5'd2;
    localparam logic [4:0] MOD_LAST  = 5'd2;

    typedef logic [KEY_W-1:0]  key_t;
    typedef logic [TKEY_W-1:0] tkey_t;

    logic [2:0]        state_reg, state_next;
    logic [4:0]        step_reg, step_next;
    logic [ADDR_W-1:0] slot_reg, slot_next;
    logic [ADDR_W-1:0] probe_cnt_reg, probe_cnt_next;
    logic              out_valid_reg, out_valid_next;

    key_t              key_p_reg, key_t_reg, key_n_reg, cand_reg;
    logic [31:0]       acc_reg, acc_next;
    logic [31:0]       quot_reg, quot_next;
    tkey_t             rd_key_reg;
    key_t              rd_res_reg;
    vkdh_pkg::status_t res_status_reg, res_status_next;
    vkdh_pkg::field_t  res_index_reg, res_index_next;
    vkdh_pkg::status_t out_status_reg;
    vkdh_pkg::field_t  out_index_reg;

    tkey_t key_mem [TABLE_SIZE];
    key_t  res_mem [TABLE_SIZE];

    logic [31:0]   mul_op, mul_k;
    logic [63:0]   prod;
    tkey_t         req_key;
    logic          slot_empty, slot_match;
    logic          key_we, res_we, out_load;
    tkey_t         key_wdata;

    assign req_key    = {key_p_reg, key_t_reg, key_n_reg};
    assign slot_empty = (rd_key_reg == '0);
    assign slot_match = (rd_key_reg == req_key);
    assign prod       = mul_op * mul_k;

    assign req.ready         = (state_reg == S_IDLE);
    assign rsp.valid         = out_valid_reg;
    assign rsp.lookup_status = out_status_reg;
    assign rsp.found_index   = out_index_reg;

    always_comb
    begin
        if (state_reg == S_MOD)
        begin
            mul_op = (step_reg == '0) ? acc_reg : quot_reg;
            mul_k  = (step_reg == '0) ? MOD_RECIP : TABLE_SIZE_32;
        end
        else
        begin
            unique case (step_reg[1:0])
                2'd0:
                begin
                    mul_op = 32'(key_p_reg);
                    mul_k  = vkdh_pkg::HASH_MUL_P;
                end
                2'd1:
                begin
                    mul_op = 32'(key_t_reg);
                    mul_k  = vkdh_pkg::HASH_MUL_T;
                end
                default:
                begin
                    mul_op = 32'(key_n_reg);
                    mul_k  = vkdh_pkg::HASH_MUL_N;
                end
            endcase
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        slot_next       = slot_reg;
        probe_cnt_next  = probe_cnt_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        acc_next        = acc_reg;
        quot_next       = quot_reg;
        res_status_next = res_status_reg;
        res_index_next  = res_index_reg;
        key_we          = 1'b0;
        res_we          = 1'b0;
        key_wdata       = req_key;
        out_load        = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                key_we    = 1'b1;
                key_wdata = '0;
                if (slot_reg == LAST_SLOT)
                begin
                    slot_next  = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    slot_next = slot_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    acc_next   = '0;
                    step_next  = '0;
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                acc_next = acc_reg ^ prod[31:0];
                if (step_reg == HASH_LAST)
                begin
                    step_next = '0;
                    if (IS_POW2)
                    begin
                        slot_next      = acc_next[ADDR_W-1:0];
                        probe_cnt_next = '0;
                        state_next     = S_PROBE;
                    end
                    else
                    begin
                        state_next = S_MOD;
                    end
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_MOD:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == '0)
                begin
                    quot_next = prod[63:32];
                end
                else if (step_reg == MOD_LAST)
                begin
                    slot_next      = (quot_reg >= TABLE_SIZE_32)
                                   ? ADDR_W'(quot_reg - TABLE_SIZE_32) : quot_reg[ADDR_W-1:0];
                    probe_cnt_next = '0;
                    state_next     = S_PROBE;
                end
                else
                begin
                    quot_next = acc_reg - prod[31:0];
                end
            end
            S_PROBE:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (slot_empty)
                begin
                    key_we          = 1'b1;
                    res_we          = 1'b1;
                    res_status_next = vkdh_pkg::STATUS_INSERTED;
                    res_index_next  = '0;
                    state_next      = S_RESP;
                end
                else if (slot_match)
                begin
                    res_status_next = vkdh_pkg::STATUS_FOUND;
                    res_index_next  = vkdh_pkg::field_t'(rd_res_reg);
                    state_next      = S_RESP;
                end
                else if (probe_cnt_reg == LAST_SLOT)
                begin
                    res_status_next = vkdh_pkg::STATUS_FULL;
                    res_index_next  = '0;
                    state_next      = S_RESP;
                end
                else
                begin
                    slot_next      = (slot_reg == LAST_SLOT) ? '0 : slot_reg + 1'b1;
                    probe_cnt_next = probe_cnt_reg + 1'b1;
                    state_next     = S_PROBE;
                end
            end
            S_RESP:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            step_reg      <= '0;
            slot_reg      <= '0;
            probe_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            slot_reg      <= slot_next;
            probe_cnt_reg <= probe_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            key_p_reg <= req.position_index[KEY_W-1:0];
            key_t_reg <= req.texcoord_index[KEY_W-1:0];
            key_n_reg <= req.normal_index[KEY_W-1:0];
            cand_reg  <= req.candidate_index[KEY_W-1:0];
        end
        acc_reg        <= acc_next;
        quot_reg       <= quot_next;
        res_status_reg <= res_status_next;
        res_index_reg  <= res_index_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_index_reg  <= res_index_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[slot_reg] <= key_wdata;
        end
        if (res_we)
        begin
            res_mem[slot_reg] <= cand_reg;
        end
        if (state_reg == S_PROBE)
        begin
            rd_key_reg <= key_mem[slot_reg];
            rd_res_reg <= res_mem[slot_reg];
        end
    end

`ifndef ASSERT_OFF
    a_accept_starts_hash: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (state_reg == S_HASH))
        else $error("accepted transaction did not start hashing");

    a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.lookup_status == vkdh_pkg::STATUS_FOUND
                    || rsp.lookup_status == vkdh_pkg::STATUS_INSERTED
                    || rsp.lookup_status == vkdh_pkg::STATUS_FULL))
        else $error("illegal lookup status");

    a_index_zero_unless_found: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.lookup_status != vkdh_pkg::STATUS_FOUND) |-> (rsp.found_index == '0))
        else $error("found index nonzero on insert or full");

    a_write_only_clear_or_insert: assert property (@(posedge clk) disable iff (!rst_n)
        key_we |-> (state_reg == S_CLEAR || (state_reg == S_CMP && slot_empty)))
        else $error("table write outside clear or insert");

    a_full_after_all_probes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP && state_next == S_RESP && !slot_empty && !slot_match)
            |-> (probe_cnt_reg == LAST_SLOT))
        else $error("full reported before every slot was probed");
`endif

endmodule
`default_nettype wire
